### design/m3i_pkg.sv
`default_nettype none
package m3i_pkg;

   localparam int ELEM_W        = 32;
   localparam int N_ELEM        = 9;
   localparam int N_ROW         = 3;
   localparam int PROD_W        = 64;
   localparam int ADJ_W         = 65;
   localparam int MAG_W         = 64;   // |adjugate| never exceeds 2^63
   localparam int DET_W         = 98;
   localparam int QUOT_W        = 34;   // top bit flags a quotient of 2^33 or more
   localparam int THR_W         = 31;
   localparam int ADJ_STAGES    = 2;
   localparam int DET_STAGES    = 3;
   localparam int MERGE_STAGES  = 1;
   localparam int DEF_FRAC_BITS = 16;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef elem_type                 mat_type [N_ELEM];
   typedef elem_type                 row_type [N_ROW];
   typedef logic signed [ADJ_W-1:0]  adj_type;
   typedef adj_type                  adj_arr_type [N_ELEM];
   typedef logic [DET_W-1:0]         mag_type;
   typedef logic [QUOT_W-1:0]        quot_type;
   typedef quot_type                 quot_arr_type [N_ELEM];

   typedef struct packed {
      logic singular;
   } det_stat_type;

endpackage
`default_nettype wire

### design/m3i_ifs.sv
`default_nettype none
interface m3i_req_if;
   logic                   valid;
   logic                   ready;
   logic signed [31:0]     in_r0c0;
   logic signed [31:0]     in_r0c1;
   logic signed [31:0]     in_r0c2;
   logic signed [31:0]     in_r1c0;
   logic signed [31:0]     in_r1c1;
   logic signed [31:0]     in_r1c2;
   logic signed [31:0]     in_r2c0;
   logic signed [31:0]     in_r2c1;
   logic signed [31:0]     in_r2c2;

   modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                   in_r2c0, in_r2c1, in_r2c2, input ready);
   modport sink   (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                   in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface

interface m3i_rsp_if;
   logic                   valid;
   logic                   ready;
   logic signed [31:0]     out_r0c0;
   logic signed [31:0]     out_r0c1;
   logic signed [31:0]     out_r0c2;
   logic signed [31:0]     out_r1c0;
   logic signed [31:0]     out_r1c1;
   logic signed [31:0]     out_r1c2;
   logic signed [31:0]     out_r2c0;
   logic signed [31:0]     out_r2c1;
   logic signed [31:0]     out_r2c2;
   logic                   singular;
   logic                   overflow;

   modport source (output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                   out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, overflow,
                   input ready);
   modport sink   (input valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                   out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, overflow,
                   output ready);
endinterface
`default_nettype wire

### design/m3i_adj.sv
`default_nettype none
module m3i_adj (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire m3i_pkg::mat_type  mat,
   output m3i_pkg::adj_arr_type   adj,
   output m3i_pkg::row_type       row0
);
   import m3i_pkg::*;

   // adj[k] = m[A]*m[B] - m[C]*m[D], row-major element indexes
   localparam int COF_A [N_ELEM] = '{4, 7, 1, 5, 8, 2, 3, 6, 0};
   localparam int COF_B [N_ELEM] = '{8, 2, 5, 6, 0, 3, 7, 1, 4};
   localparam int COF_C [N_ELEM] = '{5, 8, 2, 3, 6, 0, 4, 7, 1};
   localparam int COF_D [N_ELEM] = '{7, 1, 4, 8, 2, 5, 6, 0, 3};

   logic signed [PROD_W-1:0] ab_ff [N_ELEM];
   logic signed [PROD_W-1:0] cd_ff [N_ELEM];
   row_type                  row_s1_ff;
   adj_arr_type              adj_ff;
   row_type                  row_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N_ELEM; k++) begin
            ab_ff[k]  <= mat[COF_A[k]] * mat[COF_B[k]];
            cd_ff[k]  <= mat[COF_C[k]] * mat[COF_D[k]];
            adj_ff[k] <= ADJ_W'(ab_ff[k]) - ADJ_W'(cd_ff[k]);
         end
         for (int j = 0; j < N_ROW; j++) begin
            row_s1_ff[j] <= mat[j];
            row_ff[j]    <= row_s1_ff[j];
         end
      end
   end

   assign adj  = adj_ff;
   assign row0 = row_ff;

endmodule
`default_nettype wire

### design/m3i_det.sv
`default_nettype none
module m3i_det #(
   parameter int FRAC_BITS = m3i_pkg::DEF_FRAC_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                en,
   input  wire m3i_pkg::adj_arr_type                adj,
   input  wire m3i_pkg::row_type                    row0,
   input  wire logic [m3i_pkg::THR_W-1:0]           thr,
   output logic [m3i_pkg::MAG_W+2*FRAC_BITS-1:0]    num [m3i_pkg::N_ELEM],
   output logic                                     neg [m3i_pkg::N_ELEM],
   output m3i_pkg::mag_type                         mag,
   output m3i_pkg::det_stat_type                    stat
);
   import m3i_pkg::*;

   localparam int NUM_W  = MAG_W + 2*FRAC_BITS;
   localparam int HALF_W = ELEM_W + 33;

   logic signed [HALF_W-1:0] hi_ff [N_ROW];
   logic signed [HALF_W-1:0] lo_ff [N_ROW];
   adj_arr_type              adj_s3_ff;
   adj_arr_type              adj_s4_ff;
   logic signed [DET_W-1:0]  det_ff;
   logic signed [DET_W-1:0]  det_in;
   logic signed [DET_W-1:0]  limit;
   logic [NUM_W-1:0]         num_ff [N_ELEM];
   logic                     neg_ff [N_ELEM];
   mag_type                  mag_ff;
   det_stat_type             stat_ff;
   det_stat_type             stat_in;
   logic [MAG_W-1:0]         abs_adj [N_ELEM];

   // det = sum of row0[j] * adj[3j]; adj split into signed high and unsigned low halves
   always_comb begin
      det_in = '0;
      for (int j = 0; j < N_ROW; j++) begin
         det_in = det_in + (DET_W'(hi_ff[j]) <<< 32) + DET_W'(lo_ff[j]);
      end
   end

   assign limit = DET_W'({1'b0, thr}) << (2*FRAC_BITS);

   always_comb begin
      stat_in.singular = (det_ff == '0)
                       || (!det_ff[DET_W-1] && (det_ff < limit))
                       || ( det_ff[DET_W-1] && (det_ff > -limit));
      for (int k = 0; k < N_ELEM; k++) begin
         abs_adj[k] = adj_s4_ff[k][ADJ_W-1] ? MAG_W'(-adj_s4_ff[k]) : MAG_W'(adj_s4_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < N_ROW; j++) begin
            hi_ff[j] <= row0[j] * $signed(adj[3*j][ADJ_W-1:32]);
            lo_ff[j] <= row0[j] * $signed({1'b0, adj[3*j][31:0]});
         end
         adj_s3_ff <= adj;
         adj_s4_ff <= adj_s3_ff;
         det_ff    <= det_in;
         mag_ff    <= det_ff[DET_W-1] ? mag_type'(-det_ff) : mag_type'(det_ff);
         stat_ff   <= stat_in;
         for (int k = 0; k < N_ELEM; k++) begin
            num_ff[k] <= NUM_W'(abs_adj[k]) << (2*FRAC_BITS);
            neg_ff[k] <= adj_s4_ff[k][ADJ_W-1] ^ det_ff[DET_W-1];
         end
      end
   end

   assign num  = num_ff;
   assign neg  = neg_ff;
   assign mag  = mag_ff;
   assign stat = stat_ff;

endmodule
`default_nettype wire

### design/m3i_div_lane.sv
`default_nettype none
module m3i_div_lane #(
   parameter int FRAC_BITS = m3i_pkg::DEF_FRAC_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                en,
   input  wire logic [m3i_pkg::MAG_W+2*FRAC_BITS-1:0] num,
   input  wire logic                                neg,
   input  wire m3i_pkg::mag_type                    mag_at [m3i_pkg::QUOT_W],
   output m3i_pkg::quot_type                        quot,
   output logic                                     neg_out
);
   import m3i_pkg::*;

   localparam int NUM_W = MAG_W + 2*FRAC_BITS;
   localparam int REM_W = DET_W + QUOT_W;

   logic [REM_W-1:0] rem_ff [QUOT_W-1];
   quot_type         q_ff   [QUOT_W];
   logic             neg_ff [QUOT_W];

   // restoring division, one quotient bit per stage, MSB first
   for (genvar j = 0; j < QUOT_W; j++) begin : g_stage
      logic [REM_W-1:0] rem_prev;
      logic [REM_W-1:0] sub;
      quot_type         q_prev;
      logic             neg_prev;
      logic             ge;

      if (j == 0) begin : g_first
         assign rem_prev = REM_W'(num);
         assign q_prev   = '0;
         assign neg_prev = neg;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign q_prev   = q_ff[j-1];
         assign neg_prev = neg_ff[j-1];
      end

      assign sub = REM_W'(mag_at[j]) << (QUOT_W-1-j);
      assign ge  = (rem_prev >= sub);

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[j]   <= {q_prev[QUOT_W-2:0], ge};
            neg_ff[j] <= neg_prev;
         end
      end

      if (j < QUOT_W-1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= ge ? (rem_prev - sub) : rem_prev;
            end
         end
      end
   end

   assign quot    = q_ff[QUOT_W-1];
   assign neg_out = neg_ff[QUOT_W-1];

endmodule
`default_nettype wire

### design/m3i_merge.sv
`default_nettype none
module m3i_merge #(
   parameter int FRAC_BITS = m3i_pkg::DEF_FRAC_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire m3i_pkg::quot_arr_type    quot,
   input  wire logic                     neg [m3i_pkg::N_ELEM],
   input  wire m3i_pkg::det_stat_type    stat,
   output m3i_pkg::mat_type              res,
   output logic                          singular,
   output logic                          overflow
);
   import m3i_pkg::*;

   localparam logic [ELEM_W-1:0] ONE     = ELEM_W'(1) << FRAC_BITS;
   localparam logic [ELEM_W-1:0] POS_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
   localparam logic [ELEM_W-1:0] NEG_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

   mat_type res_ff;
   mat_type res_in;
   logic    sing_ff;
   logic    ovf_ff;
   logic    ovf_in;

   always_comb begin
      logic [QUOT_W-2:0] qq;
      logic              sat;
      ovf_in = 1'b0;
      for (int k = 0; k < N_ELEM; k++) begin
         qq = quot[k][QUOT_W-2:0];
         if (neg[k]) begin
            sat       = quot[k][QUOT_W-1] || (qq > (QUOT_W-1)'(NEG_MIN));
            res_in[k] = sat ? NEG_MIN : -qq[ELEM_W-1:0];
         end else begin
            sat       = quot[k][QUOT_W-1] || (qq > (QUOT_W-1)'(POS_MAX));
            res_in[k] = sat ? POS_MAX : qq[ELEM_W-1:0];
         end
         if (stat.singular) begin
            res_in[k] = (k % 4 == 0) ? ONE : '0;
         end
         ovf_in = ovf_in | sat;
      end
      if (stat.singular) begin
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff  <= res_in;
         sing_ff <= stat.singular;
         ovf_ff  <= ovf_in;
      end
   end

   assign res      = res_ff;
   assign singular = sing_ff;
   assign overflow = ovf_ff;

endmodule
`default_nettype wire

### design/matrix3x3_inverse_unit.sv
`default_nettype none
// 3x3 fixed-point matrix inverse (adjugate / determinant).
// Throughput: one matrix per cycle; nine divider lanes, one quotient bit per stage.
// The whole pipeline holds while a result waits on rsp.ready.
// Reset (synchronous, active high) empties the pipeline and sets threshold to 1.
module matrix3x3_inverse_unit #(
   parameter int FRAC_BITS = m3i_pkg::DEF_FRAC_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   m3i_req_if.sink                         req,
   m3i_rsp_if.source                       rsp,
   input  wire logic                       csr_we,
   input  wire logic [m3i_pkg::THR_W-1:0]  csr_wdata
);
   import m3i_pkg::*;

   localparam int NUM_W  = MAG_W + 2*FRAC_BITS;
   localparam int DEPTH  = ADJ_STAGES + DET_STAGES + QUOT_W + MERGE_STAGES;

   logic [THR_W-1:0] thr_ff;
   logic [DEPTH-1:0] vld_ff;
   logic             en;

   mat_type          mat;
   adj_arr_type      adj;
   row_type          row0;
   logic [NUM_W-1:0] num [N_ELEM];
   logic             neg [N_ELEM];
   mag_type          mag;
   det_stat_type     stat;
   mag_type          mag_at [QUOT_W];
   mag_type          mag_dly_ff [QUOT_W-1];
   det_stat_type     stat_dly_ff [QUOT_W];
   quot_arr_type     quot;
   logic             neg_q [N_ELEM];
   mat_type          res;
   logic             sing;
   logic             ovf;

   // pipeline moves whenever the output slot is empty or being taken
   assign en        = !vld_ff[DEPTH-1] || rsp.ready;
   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_W'(1);
         vld_ff <= '0;
      end else begin
         if (csr_we) begin
            thr_ff <= csr_wdata;
         end
         if (en) begin
            vld_ff <= {vld_ff[DEPTH-2:0], req.valid};
         end
      end
   end

   assign mat[0] = req.in_r0c0;
   assign mat[1] = req.in_r0c1;
   assign mat[2] = req.in_r0c2;
   assign mat[3] = req.in_r1c0;
   assign mat[4] = req.in_r1c1;
   assign mat[5] = req.in_r1c2;
   assign mat[6] = req.in_r2c0;
   assign mat[7] = req.in_r2c1;
   assign mat[8] = req.in_r2c2;

   // cofactor products and adjugate
   m3i_adj u_adj (
      .clock (clock),
      .en    (en),
      .mat   (mat),
      .adj   (adj),
      .row0  (row0)
   );

   // determinant, singular test, lane numerators and signs
   m3i_det #(.FRAC_BITS(FRAC_BITS)) u_det (
      .clock (clock),
      .en    (en),
      .adj   (adj),
      .row0  (row0),
      .thr   (thr_ff),
      .num   (num),
      .neg   (neg),
      .mag   (mag),
      .stat  (stat)
   );

   // divisor magnitude travels beside the lanes, shared by all nine
   assign mag_at[0] = mag;
   for (genvar j = 1; j < QUOT_W; j++) begin : g_mag
      assign mag_at[j] = mag_dly_ff[j-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < QUOT_W-1; j++) begin
            mag_dly_ff[j] <= mag_at[j];
         end
         stat_dly_ff[0] <= stat;
         for (int j = 1; j < QUOT_W; j++) begin
            stat_dly_ff[j] <= stat_dly_ff[j-1];
         end
      end
   end

   for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
      m3i_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock   (clock),
         .en      (en),
         .num     (num[k]),
         .neg     (neg[k]),
         .mag_at  (mag_at),
         .quot    (quot[k]),
         .neg_out (neg_q[k])
      );
   end

   // saturation, identity on singular, output register
   m3i_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
      .clock    (clock),
      .en       (en),
      .quot     (quot),
      .neg      (neg_q),
      .stat     (stat_dly_ff[QUOT_W-1]),
      .res      (res),
      .singular (sing),
      .overflow (ovf)
   );

   assign rsp.valid    = vld_ff[DEPTH-1];
   assign rsp.out_r0c0 = res[0];
   assign rsp.out_r0c1 = res[1];
   assign rsp.out_r0c2 = res[2];
   assign rsp.out_r1c0 = res[3];
   assign rsp.out_r1c1 = res[4];
   assign rsp.out_r1c2 = res[5];
   assign rsp.out_r2c0 = res[6];
   assign rsp.out_r2c1 = res[7];
   assign rsp.out_r2c2 = res[8];
   assign rsp.singular = sing;
   assign rsp.overflow = ovf;

endmodule
`default_nettype wire

### tb/sv/matrix3x3_inverse_unit_tb.sv
`timescale 1ns / 100ps
`default_nettype none
// Self-checking bench for the 3x3 fixed-point matrix inverse unit.
// A directed table is followed by random matrices under several singular
// thresholds. Typed rows are checked against hand-written results, others
// against an in-bench model: adjugate / determinant, truncated, saturated.
module matrix3x3_inverse_unit_tb;
   import m3i_pkg::*;

   localparam int FB       = DEF_FRAC_BITS;
   localparam int DRAIN    = 60;          // longer than the pipeline is deep
   localparam int N_RANDOM = 1330;

   typedef elem_type mat9_type [N_ELEM];

   typedef struct {
      elem_type e [N_ELEM];
      logic     singular;
      logic     overflow;
   } inv_result_type;

   typedef struct {
      elem_type       m [N_ELEM];
      bit             typed;      // expected result written in by hand
      inv_result_type res;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [THR_W-1:0] csr_wdata = '0;

   m3i_req_if req_if ();
   m3i_rsp_if rsp_if ();

   matrix3x3_inverse_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Bench copy of the threshold register; only changes while the unit is idle.
   logic [THR_W-1:0] thr_shadow = 1;

   // Idle/stall percentages, changed per phase.
   int unsigned snd_idle_pct = 0;
   int unsigned rcv_stall_pct = 0;

   inv_result_type pending_inverses [$];
   int             n_errors = 0;

   // ------------------------------------------------------------------------
   // Inverse predictor: exact adjugate and determinant in 128-bit signed math,
   // then |adj| * 2^(2F) / |det| truncated toward zero and saturated to 32 bits.
   // ------------------------------------------------------------------------
   function automatic logic signed [127:0] cross_diff(elem_type a, elem_type b,
                                                      elem_type c, elem_type d);
      logic signed [127:0] pa, pb, pc, pd;
      pa = a; pb = b; pc = c; pd = d;
      return pa * pb - pc * pd;
   endfunction

   function automatic inv_result_type identity_result(elem_type one);
      inv_result_type r;
      foreach (r.e[i]) r.e[i] = (i % 4 == 0) ? one : '0;
      r.singular = 1'b0;
      r.overflow = 1'b0;
      return r;
   endfunction

   function automatic inv_result_type predict_inverse(mat9_type m, logic [THR_W-1:0] thr);
      logic signed [127:0] adj [N_ELEM];
      logic signed [127:0] det, m0, m1, m2;
      logic [127:0] mag, lim, num, quo;
      inv_result_type r;
      bit neg;
      adj[0] = cross_diff(m[4], m[8], m[5], m[7]);
      adj[1] = cross_diff(m[7], m[2], m[8], m[1]);
      adj[2] = cross_diff(m[1], m[5], m[2], m[4]);
      adj[3] = cross_diff(m[5], m[6], m[3], m[8]);
      adj[4] = cross_diff(m[8], m[0], m[6], m[2]);
      adj[5] = cross_diff(m[2], m[3], m[0], m[5]);
      adj[6] = cross_diff(m[3], m[7], m[4], m[6]);
      adj[7] = cross_diff(m[6], m[1], m[7], m[0]);
      adj[8] = cross_diff(m[0], m[4], m[1], m[3]);
      m0 = m[0]; m1 = m[1]; m2 = m[2];
      det = m0 * adj[0] + m1 * adj[3] + m2 * adj[6];
      mag = (det < 0) ? -det : det;
      lim = 128'(thr) << (2 * FB);
      if (mag == 0 || mag < lim) begin
         r = identity_result(elem_type'(1 << FB));
         r.singular = 1'b1;
         return r;
      end
      r.singular = 1'b0;
      r.overflow = 1'b0;
      for (int i = 0; i < N_ELEM; i++) begin
         neg = (adj[i] < 0) != (det < 0);
         num = (adj[i] < 0) ? -adj[i] : adj[i];
         quo = (num << (2 * FB)) / mag;
         if (neg) begin
            if (quo > 128'h8000_0000) begin
               r.e[i] = 32'h8000_0000;
               r.overflow = 1'b1;
            end else begin
               r.e[i] = elem_type'(-quo);
            end
         end else begin
            if (quo > 128'h7FFF_FFFF) begin
               r.e[i] = 32'h7FFF_FFFF;
               r.overflow = 1'b1;
            end else begin
               r.e[i] = elem_type'(quo);
            end
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request side: optional idle gap, then hold valid until the transfer.
   // Inputs are driven on the falling edge, ready is sampled on the rising.
   // ------------------------------------------------------------------------
   task automatic send_matrix(mat9_type m, bit typed, inv_result_type typed_res);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      {req_if.in_r0c0, req_if.in_r0c1, req_if.in_r0c2} = {m[0], m[1], m[2]};
      {req_if.in_r1c0, req_if.in_r1c1, req_if.in_r1c2} = {m[3], m[4], m[5]};
      {req_if.in_r2c0, req_if.in_r2c1, req_if.in_r2c2} = {m[6], m[7], m[8]};
      req_if.valid = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      // transfer happened at this edge
      pending_inverses.push_back(typed ? typed_res : predict_inverse(m, thr_shadow));
      @(negedge clock);
   endtask

   // Threshold writes only with the pipeline empty and settled.
   task automatic write_threshold(logic [THR_W-1:0] v);
      req_if.valid = 1'b0;
      wait (pending_inverses.size() == 0);
      repeat (DRAIN) @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_we     = 1'b0;
      thr_shadow = v;
   endtask

   function automatic elem_type rand_elem(int unsigned kind);
      case (kind)
         0, 1: return elem_type'($urandom);
         2, 3, 4, 5: return elem_type'($signed($urandom_range(1 << 18)) - (1 << 17));
         6: return elem_type'($signed($urandom_range(32)) - 16);
         8: begin
            case ($urandom_range(5))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return '0;
               3: return 32'sd1;
               4: return -32'sd1;
               default: return elem_type'($urandom);
            endcase
         end
         default: return elem_type'($signed($urandom_range(1 << 25)) - (1 << 24));
      endcase
   endfunction

   // Diagonally dominant matrices in four kinds of ten, medium random content;
   // the rest is wide noise, tiny raw values, extremes and rank-deficient ones.
   function automatic mat9_type rand_matrix();
      mat9_type m;
      int unsigned kind;
      kind = $urandom_range(9);
      foreach (m[i]) m[i] = rand_elem(kind);
      if (kind >= 2 && kind <= 5) begin
         for (int d = 0; d < 3; d++) begin
            m[d * 4] = elem_type'($urandom_range(1 << 20, 1 << 18));
            if ($urandom_range(1)) m[d * 4] = -m[d * 4];
         end
      end else if (kind == 7) begin
         m[6] = m[0]; m[7] = m[1]; m[8] = m[2];    // repeated row: det is zero
      end
      return m;
   endfunction

   // ------------------------------------------------------------------------
   // Response side: random stalls, compare each transfer with the oldest entry.
   // ------------------------------------------------------------------------
   always @(negedge clock)
      rsp_if.ready <= ($urandom_range(99) >= rcv_stall_pct);

   always @(posedge clock) begin
      inv_result_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.e = '{rsp_if.out_r0c0, rsp_if.out_r0c1, rsp_if.out_r0c2,
                   rsp_if.out_r1c0, rsp_if.out_r1c1, rsp_if.out_r1c2,
                   rsp_if.out_r2c0, rsp_if.out_r2c1, rsp_if.out_r2c2};
         got.singular = rsp_if.singular;
         got.overflow = rsp_if.overflow;
         if (pending_inverses.size() == 0) begin
            $error("unexpected result transfer");
            n_errors++;
         end else begin
            want = pending_inverses.pop_front();
            for (int i = 0; i < N_ELEM; i++)
               if (got.e[i] !== want.e[i]) begin
                  $error("out_r%0dc%0d: expected %h, got %h", i / 3, i % 3,
                         want.e[i], got.e[i]);
                  n_errors++;
               end
            if (got.singular !== want.singular) begin
               $error("singular: expected %b, got %b", want.singular, got.singular);
               n_errors++;
            end
            if (got.overflow !== want.overflow) begin
               $error("overflow: expected %b, got %b", want.overflow, got.overflow);
               n_errors++;
            end
         end
      end
   end

   // Hard stop, far beyond the slowest legal run.
   initial begin
      #8_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      dir_row_type    dir_rows [$];
      dir_row_type    row;
      inv_result_type sing_id;
      logic [THR_W-1:0] phase_thr [6];
      elem_type       one, mx, mn;

      one = elem_type'(1 << FB);
      mx  = 32'h7FFF_FFFF;
      mn  = 32'h8000_0000;
      sing_id = identity_result(one);
      sing_id.singular = 1'b1;

      req_if.valid = 1'b0;
      {req_if.in_r0c0, req_if.in_r0c1, req_if.in_r0c2} = '0;
      {req_if.in_r1c0, req_if.in_r1c1, req_if.in_r1c2} = '0;
      {req_if.in_r2c0, req_if.in_r2c1, req_if.in_r2c2} = '0;
      rsp_if.ready = 1'b0;

      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Directed table, run under the reset threshold (1.0 LSB of magnitude).
      row.typed = 1'b1;
      row.m = '{default: '0};                               row.res = sing_id;
      dir_rows.push_back(row);                               // zero matrix
      row.m = '{one, 0, 0, 0, one, 0, 0, 0, one};           row.res = identity_result(one);
      dir_rows.push_back(row);
      row.m = '{-one, 0, 0, 0, -one, 0, 0, 0, -one};        row.res = identity_result(-one);
      dir_rows.push_back(row);
      row.m = '{default: mx};                                row.res = sing_id;
      dir_rows.push_back(row);                               // equal rows
      row.m = '{default: mn};                                row.res = sing_id;
      dir_rows.push_back(row);
      row.m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                  row.res = sing_id;
      dir_rows.push_back(row);                               // tiny det, under threshold
      row.m = '{one, 2 * one, 3 * one, 4 * one, 5 * one, 6 * one, 7 * one, 8 * one, 9 * one};
      row.res = sing_id;
      dir_rows.push_back(row);                               // rank two
      row.typed = 1'b0;
      row.m = '{mx, 0, 0, 0, mx, 0, 0, 0, mx};               dir_rows.push_back(row);
      row.m = '{mn, 0, 0, 0, mn, 0, 0, 0, mn};               dir_rows.push_back(row);
      row.m = '{mn, mx, 0, mx, mn, 1, 0, -1, mx};            dir_rows.push_back(row);
      row.m = '{2 * one, 0, 0, 0, 4 * one, 0, 0, 0, one / 2}; dir_rows.push_back(row);
      row.m = '{0, one, 0, 0, 0, one, one, 0, 0};            dir_rows.push_back(row);
      row.m = '{one, 0, 0, 0, one, 0, 0, 0, 1};              dir_rows.push_back(row);
      row.m = '{one, 0, 0, 0, one, 0, 0, 0, -1};             dir_rows.push_back(row);
      row.m = '{3 * one, one, -one, one / 4, -2 * one, 5, 7, one, one};
      dir_rows.push_back(row);
      row.m = '{-1, mx, mn, 5, -7, 65535, mn, 1, mx};        dir_rows.push_back(row);

      snd_idle_pct  = 27;
      rcv_stall_pct = 57;
      foreach (dir_rows[k]) send_matrix(dir_rows[k].m, dir_rows[k].typed, dir_rows[k].res);

      // Random part: threshold zero, maximum, random, 1.0, reset value and zero again.
      phase_thr = '{0, THR_W'('1), THR_W'($urandom), THR_W'(1 << FB), 1, 0};
      for (int ph = 0; ph < 6; ph++) begin
         write_threshold(phase_thr[ph]);
         case (ph / 2)
            0: begin snd_idle_pct = 27; rcv_stall_pct = 57; end
            1: begin snd_idle_pct = 57; rcv_stall_pct = 27; end
            default: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
         endcase
         repeat (N_RANDOM / 6) send_matrix(rand_matrix(), 1'b0, sing_id);
      end
      req_if.valid = 1'b0;

      wait (pending_inverses.size() == 0);
      repeat (DRAIN) @(posedge clock);
      if (n_errors == 0 && pending_inverses.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
`default_nettype wire

### sim.f
design/m3i_pkg.sv
design/m3i_ifs.sv
design/m3i_adj.sv
design/m3i_det.sv
design/m3i_div_lane.sv
design/m3i_merge.sv
design/matrix3x3_inverse_unit.sv
tb/sv/matrix3x3_inverse_unit_tb.sv
